>>> design/multi_key_record_sorter_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef MULTI_KEY_RECORD_SORTER_UNIT_ASSERT_SVH
`define MULTI_KEY_RECORD_SORTER_UNIT_ASSERT_SVH
// Implication checked at every rising edge outside reset.
`define MKRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define MKRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/mkrs_pkg.sv
// ----------------------------------------------------------------------------
// mkrs_pkg
// Record type and field widths of the multi-key record sorter.
// ----------------------------------------------------------------------------
package mkrs_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned NameW  = 64;
  localparam int unsigned TailW  = 24;

  typedef struct packed {
    logic [CountW-1:0] severe;
    logic [CountW-1:0] moderate;
    logic [CountW-1:0] normal;
    logic [CountW-1:0] staff;
    logic [NameW-1:0]  head;
    logic [NameW-1:0]  mid;
    logic [TailW-1:0]  tail;
  } rec_t;

  // Full composite key, larger key goes first.
  function automatic logic [CountW*4+NameW*2+TailW-1:0] sort_key(input rec_t r);
    sort_key = {r.severe, r.moderate, r.normal, ~r.staff, ~r.head, ~r.mid, ~r.tail};
  endfunction

endpackage

>>> design/mkrs_if.sv
// ----------------------------------------------------------------------------
// mkrs_in_if / mkrs_out_if
// Valid/ready channels for input records and sorted records.
// ----------------------------------------------------------------------------
interface mkrs_in_if;
  logic                      valid;
  logic                      ready;
  logic [15:0]               severe_count;
  logic [15:0]               medium_count;
  logic [15:0]               normal_count;
  logic [15:0]               staff_count;
  logic [63:0]               name_bytes_head;
  logic [63:0]               name_bytes_mid;
  logic [23:0]               name_bytes_tail;
  logic                      last_record;
  modport source (output valid, severe_count, medium_count, normal_count, staff_count,
                  name_bytes_head, name_bytes_mid, name_bytes_tail, last_record,
                  input ready);
  modport sink   (input valid, severe_count, medium_count, normal_count, staff_count,
                  name_bytes_head, name_bytes_mid, name_bytes_tail, last_record,
                  output ready);
endinterface

interface mkrs_out_if;
  logic                      valid;
  logic                      ready;
  logic [15:0]               out_severe;
  logic [15:0]               out_medium;
  logic [15:0]               out_normal;
  logic [15:0]               out_staff;
  logic [63:0]               out_name_head;
  logic [63:0]               out_name_mid;
  logic [23:0]               out_name_tail;
  logic                      end_of_run;
  modport source (output valid, out_severe, out_medium, out_normal, out_staff,
                  out_name_head, out_name_mid, out_name_tail, end_of_run,
                  input ready);
  modport sink   (input valid, out_severe, out_medium, out_normal, out_staff,
                  out_name_head, out_name_mid, out_name_tail, end_of_run,
                  output ready);
endinterface

>>> design/multi_key_record_sorter_unit.sv
// ----------------------------------------------------------------------------
// multi_key_record_sorter_unit
// Collects records in a memory, sorts them by insertion on the last record,
// then streams them out in key order.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   four counts, 19-byte name, last flag
// out_o     out  valid/ready   four counts, 19-byte name, end-of-run flag
//
// Load: one request per cycle; each record is written to the next slot until MAX_RECORDS are held.
// Sort: insertion sort over one memory port pair; each compare/shift step
//   is a read state followed by a compare+write state.
// Drain: a skid-free read + output register; each read waits for the last
//   to land and the output slot to free. Input is held off during sort and
//   drain. Reset clears only the control state; memory needs no clear.
module multi_key_record_sorter_unit #(
  parameter int unsigned MAX_RECORDS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mkrs_in_if.sink   in_i,
  mkrs_out_if.source out_o
);

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_OUTER = 3'd1;  // start placing record i
  localparam logic [2:0] ST_RDJ   = 3'd2;  // read entry j-1
  localparam logic [2:0] ST_CMP   = 3'd3;  // compare key with entry j-1
  localparam logic [2:0] ST_DRAIN = 3'd4;

  mkrs_pkg::rec_t mem_q [MAX_RECORDS];

  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  held_q, held_d;
  logic [CW-1:0]  i_q, i_d;          // outer index
  logic [CW-1:0]  j_q, j_d;          // hole position
  mkrs_pkg::rec_t key_q, key_d;      // record being inserted
  logic [CW-1:0]  rd_cnt_q, rd_cnt_d; // drain read pointer
  logic [CW-1:0]  out_cnt_q, out_cnt_d;

  // memory port control
  logic           we;
  logic [AW-1:0]  wa;
  mkrs_pkg::rec_t wd;
  logic           re;
  logic [AW-1:0]  ra;
  mkrs_pkg::rec_t rd_q;

  // output register
  logic           ov_q, ov_d;
  mkrs_pkg::rec_t od_q, od_d;
  logic           oe_q, oe_d;
  logic           pend_q, pend_d;     // read data lands this cycle

  mkrs_pkg::rec_t in_rec;
  logic           in_fire, out_fire, goes_first;

  always_comb begin
    in_rec.severe   = in_i.severe_count;
    in_rec.moderate = in_i.medium_count;
    in_rec.normal   = in_i.normal_count;
    in_rec.staff    = in_i.staff_count;
    in_rec.head     = in_i.name_bytes_head;
    in_rec.mid      = in_i.name_bytes_mid;
    in_rec.tail     = in_i.name_bytes_tail;
  end

  assign in_i.ready = (state_q == ST_LOAD);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = ov_q && out_o.ready;
  assign goes_first = mkrs_pkg::sort_key(key_q) > mkrs_pkg::sort_key(rd_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  always_comb begin
    state_d = state_q; held_d = held_q; i_d = i_q; j_d = j_q; key_d = key_q;
    rd_cnt_d = rd_cnt_q; out_cnt_d = out_cnt_q;
    ov_d = ov_q; od_d = od_q; oe_d = oe_q; pend_d = 1'b0;
    we = 1'b0; wa = '0; wd = in_rec; re = 1'b0; ra = '0;
    if (out_fire) begin
      ov_d = 1'b0;
    end
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (held_q < CW'(MAX_RECORDS)) begin
            we = 1'b1; wa = held_q[AW-1:0]; held_d = held_q + 1'b1;
          end
          if (in_i.last_record) begin
            i_d = CW'(1);
            state_d = ST_OUTER;
          end
        end
      end
      ST_OUTER: begin
        if (i_q >= held_q) begin
          rd_cnt_d = '0; out_cnt_d = '0;
          state_d = (held_q == '0) ? ST_LOAD : ST_DRAIN;
        end else begin
          re = 1'b1; ra = i_q[AW-1:0];
          j_d = i_q;
          state_d = ST_RDJ;
        end
      end
      ST_RDJ: begin
        // first pass: rd_q holds entry i, latch as key
        if (j_q == i_q) begin
          key_d = rd_q;
        end
        re = 1'b1; ra = AW'(j_q - 1'b1);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        we = 1'b1;
        if (goes_first) begin
          wa = j_q[AW-1:0]; wd = rd_q;  // shift entry j-1 up
          j_d = j_q - 1'b1;
          if (j_q == CW'(1)) begin
            state_d = ST_CMP;  // write key at 0 next
            j_d = '0;
          end else begin
            state_d = ST_RDJ;
          end
        end else begin
          wa = j_q[AW-1:0]; wd = key_q;
          i_d = i_q + 1'b1;
          state_d = ST_OUTER;
        end
        if (j_q == '0) begin
          wa = '0; wd = key_q;
          i_d = i_q + 1'b1;
          state_d = ST_OUTER;
        end
      end
      ST_DRAIN: begin
        if (pend_q) begin
          ov_d = 1'b1; od_d = rd_q;
          oe_d = (out_cnt_q + 1'b1 == held_q);
          out_cnt_d = out_cnt_q + 1'b1;
        end
        // issue a read when the output slot will be free when data lands
        if (rd_cnt_q < held_q && !pend_q && (!ov_q || out_fire)) begin
          re = 1'b1; ra = rd_cnt_q[AW-1:0];
          rd_cnt_d = rd_cnt_q + 1'b1; pend_d = 1'b1;
        end
        if (out_fire && oe_q) begin
          held_d = '0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; held_q <= '0; i_q <= '0; j_q <= '0;
      rd_cnt_q <= '0; out_cnt_q <= '0; ov_q <= 1'b0; oe_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d; held_q <= held_d; i_q <= i_d; j_q <= j_d;
      rd_cnt_q <= rd_cnt_d; out_cnt_q <= out_cnt_d; ov_q <= ov_d; oe_q <= oe_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    od_q  <= od_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.out_severe    = od_q.severe;
  assign out_o.out_medium    = od_q.moderate;
  assign out_o.out_normal    = od_q.normal;
  assign out_o.out_staff     = od_q.staff;
  assign out_o.out_name_head = od_q.head;
  assign out_o.out_name_mid  = od_q.mid;
  assign out_o.out_name_tail = od_q.tail;
  assign out_o.end_of_run    = oe_q;

endmodule

>>> design/mkrs_checker.sv
// ----------------------------------------------------------------------------
// mkrs_checker
// Port-level checks of the sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_key_record_sorter_unit_assert.svh"
module mkrs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_end
);
  // no input taken while results stream out
  `MKRS_ASSERT_IMP(a_no_in_during_out, clk_i, rst_ni, out_valid, !in_ready)
  // a stalled result keeps its end flag
  `MKRS_ASSERT_NXT(a_end_hold, clk_i, rst_ni, out_valid && !out_ready, out_end == $past(out_end))
  // after the final result goes, the block reopens for records
  `MKRS_ASSERT_NXT(a_reopen, clk_i, rst_ni, out_valid && out_ready && out_end, in_ready)
endmodule

bind multi_key_record_sorter_unit mkrs_checker u_mkrs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_end   (out_o.end_of_run)
);
